/* hdl/tst_pkg.sv */
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants for the topic subscription table.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int unsigned NUM_SLOTS_DEF  = 32;
  localparam int unsigned TOPIC_BITS_DEF = 16;

  localparam int unsigned REQ_W      = 3;
  localparam int unsigned TOPIC_W    = 16;
  localparam int unsigned SLOT_ID_W  = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_NUM_W = 5;
  localparam int unsigned TOTAL_W    = 6;
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_LIMIT  = 2'd1;

  localparam logic [CFG_W-1:0]   CFG_RESET_VAL = 6'd32;
  localparam logic [CFG_W-1:0]   MAX_MATCHES   = 6'd32;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT     = 6'd63;

  typedef enum logic [REQ_W-1:0] {
    REQ_SUBSCRIBE = 3'd0,
    REQ_CANCEL    = 3'd1,
    REQ_QUERY     = 3'd2,
    REQ_MATCH     = 3'd3,
    REQ_COUNT     = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_RANGE    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_NOTSUB   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_REPLY,
    S_EMIT
  } tst_state_e;

  typedef struct packed {
    logic load;
    logic lookup;
    logic scan;
    logic emit_init;
    logic emit_step;
    logic emit_load;
    logic reply_load;
  } tst_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic emit_go;
    logic emit_hit;
    logic emit_last;
    logic out_free;
  } tst_sts_t;

endpackage

/* hdl/tst_ctrl.sv */
// ----------------------------------------------------------------------------
// tst_ctrl
// Request sequencer: accepts a request and steps the datapath through
// lookup, slot scan, reply and match emission.
// ----------------------------------------------------------------------------
module tst_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [tst_pkg::REQ_W-1:0]      req_type_i,
  output logic                           in_stall_o,
  input  tst_pkg::tst_sts_t              sts_i,
  output tst_pkg::tst_cmd_t              cmd_o
);
  import tst_pkg::*;

  tst_state_e state_q, state_d;
  req_e       req_in;

  assign req_in = req_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          priority if (req_in == REQ_CANCEL || req_in == REQ_QUERY) begin
            state_d = S_LOOKUP;
          end else if (req_in == REQ_SUBSCRIBE || req_in == REQ_MATCH ||
                       req_in == REQ_COUNT) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_REPLY;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.emit_go) begin
            cmd_o.emit_init = 1'b1;
            state_d         = S_EMIT;
          end else begin
            state_d = S_REPLY;
          end
        end
      end
      S_REPLY: begin
        if (sts_i.out_free) begin
          cmd_o.reply_load = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.emit_hit) begin
          if (sts_i.out_free) begin
            cmd_o.emit_load = 1'b1;
            if (sts_i.emit_last) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          cmd_o.emit_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/tst_datapath.sv */
// ----------------------------------------------------------------------------
// tst_datapath
// Slot table storage, configuration registers, scan pipeline, hit vector and
// the output register.
// ----------------------------------------------------------------------------
module tst_datapath #(
  parameter int unsigned NUM_SLOTS  = tst_pkg::NUM_SLOTS_DEF,
  parameter int unsigned TOPIC_BITS = tst_pkg::TOPIC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [tst_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tst_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [tst_pkg::REQ_W-1:0]           req_type_i,
  input  logic [tst_pkg::TOPIC_W-1:0]         topic_i,
  input  logic [tst_pkg::SLOT_ID_W-1:0]       slot_id_i,
  input  tst_pkg::tst_cmd_t                   cmd_i,
  output tst_pkg::tst_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tst_pkg::STATUS_W-1:0]        status_o,
  output logic [tst_pkg::SLOT_NUM_W-1:0]      slot_number_o,
  output logic [tst_pkg::TOPIC_W-1:0]         slot_topic_out_o,
  output logic [tst_pkg::TOTAL_W-1:0]         total_o,
  output logic                                last_o
);
  import tst_pkg::*;

  localparam int unsigned IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNTW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned STW  = (TOPIC_BITS < TOPIC_W) ? TOPIC_BITS : TOPIC_W;

  // configuration
  logic [CFG_W-1:0] slots_in_use_q, match_limit_q;
  logic [31:0]      n_w;
  logic [CFG_W-1:0] lim;
  logic [CNTW-1:0]  n;

  // request
  req_e                 req_q;
  logic [STW-1:0]       tp_q;
  logic [SLOT_ID_W-1:0] id_q;
  logic [31:0]          id_w;
  logic [IDXW-1:0]      id_idx;
  logic                 id_in_range;

  // table
  logic [STW-1:0]       topic_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_q;

  // scan
  logic [CNTW-1:0]      ptr_q, k_q, cnt_q;
  logic [IDXW-1:0]      ptr_idx;
  logic                 ptr_lt_n;
  logic                 rd_vld_q, rd_used_q;
  logic [IDXW-1:0]      rd_idx_q, raddr;
  logic [STW-1:0]       rd_topic_q;
  logic                 mem_re;
  logic [NUM_SLOTS-1:0] hit_q;
  logic                 found_q;
  logic [IDXW-1:0]      first_q;
  logic                 rd_hit;

  // output
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q,  status_d;
  logic [SLOT_NUM_W-1:0] slot_q,    slot_d;
  logic [TOPIC_W-1:0]    otopic_q,  otopic_d;
  logic [TOTAL_W-1:0]    total_q,   total_d;
  logic                  last_q,    last_d;
  logic                  out_free;
  logic [TOTAL_W-1:0]    total_sat;
  logic [31:0]           tp_w, rdt_w, first_w, id_slot_w, ptr_w, cnt_w;

  // derived
  assign n_w  = (32'(slots_in_use_q) > NUM_SLOTS) ? NUM_SLOTS : 32'(slots_in_use_q);
  assign n    = n_w[CNTW-1:0];
  assign lim  = (match_limit_q > MAX_MATCHES) ? MAX_MATCHES : match_limit_q;

  assign id_w        = 32'(id_q);
  assign id_idx      = id_w[IDXW-1:0];
  assign id_in_range = id_w < 32'(n);

  assign ptr_idx  = ptr_q[IDXW-1:0];
  assign ptr_lt_n = ptr_q < n;
  assign mem_re   = cmd_i.lookup || (cmd_i.scan && ptr_lt_n);
  assign raddr    = cmd_i.lookup ? id_idx : ptr_idx;

  assign cnt_w     = 32'(cnt_q);
  assign total_sat = (cnt_w > 32'(TOTAL_SAT)) ? TOTAL_SAT : cnt_w[TOTAL_W-1:0];
  assign tp_w      = 32'(tp_q);
  assign rdt_w     = 32'(rd_topic_q);
  assign first_w   = 32'(first_q);
  assign id_slot_w = 32'(id_q);
  assign ptr_w     = 32'(ptr_q);

  assign rd_hit = rd_used_q &&
                  ((req_q == REQ_COUNT) || ((req_q == REQ_MATCH) && (rd_topic_q == tp_q)));

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.scan_done = !ptr_lt_n && !rd_vld_q;
  assign sts_o.emit_go   = (req_q == REQ_MATCH) && (cnt_q != '0) && (cnt_w <= 32'(lim));
  assign sts_o.emit_hit  = ptr_lt_n && hit_q[ptr_idx];
  assign sts_o.emit_last = (k_q + CNTW'(1)) == cnt_q;
  assign sts_o.out_free  = out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= CFG_RESET_VAL;
      match_limit_q  <= CFG_RESET_VAL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SLOTS_IN_USE: slots_in_use_q <= cfg_data_i;
        REG_MATCH_LIMIT:  match_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_type_i);
      tp_q  <= topic_i[STW-1:0];
      id_q  <= slot_id_i;
    end
  end

  // topic memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.reply_load && req_q == REQ_SUBSCRIBE && found_q) begin
      topic_mem[first_q] <= tp_q;
    end
    if (mem_re) begin
      rd_topic_q <= topic_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_used_q <= used_q[raddr];
      rd_idx_q  <= raddr;
    end
  end

  // slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.reply_load) begin
      if (req_q == REQ_SUBSCRIBE && found_q) begin
        used_q[first_q] <= 1'b1;
      end else if (req_q == REQ_CANCEL && id_in_range && rd_used_q) begin
        used_q[id_idx] <= 1'b0;
      end
    end
  end

  // scan pointer, hit vector and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      k_q      <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= '0;
      found_q  <= 1'b0;
      first_q  <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan && ptr_lt_n;
      if (cmd_i.load) begin
        ptr_q   <= '0;
        k_q     <= '0;
        cnt_q   <= '0;
        hit_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.emit_init) begin
        ptr_q <= '0;
        k_q   <= '0;
      end else if (cmd_i.emit_step) begin
        ptr_q <= ptr_q + CNTW'(1);
      end else if (cmd_i.emit_load) begin
        ptr_q <= ptr_q + CNTW'(1);
        k_q   <= k_q + CNTW'(1);
      end else if (cmd_i.scan && ptr_lt_n) begin
        ptr_q <= ptr_q + CNTW'(1);
      end
      if (rd_vld_q) begin
        if (rd_hit) begin
          hit_q[rd_idx_q] <= 1'b1;
          cnt_q           <= cnt_q + CNTW'(1);
        end
        if (req_q == REQ_SUBSCRIBE && !rd_used_q && !found_q) begin
          found_q <= 1'b1;
          first_q <= rd_idx_q;
        end
      end
    end
  end

  // result selection
  always_comb begin
    status_d = ST_OK;
    slot_d   = '0;
    otopic_d = '0;
    total_d  = '0;
    last_d   = 1'b1;
    if (cmd_i.emit_load) begin
      slot_d   = ptr_w[SLOT_NUM_W-1:0];
      otopic_d = tp_w[TOPIC_W-1:0];
      total_d  = total_sat;
      last_d   = sts_o.emit_last;
    end else begin
      unique case (req_q)
        REQ_SUBSCRIBE: begin
          if (found_q) begin
            slot_d   = first_w[SLOT_NUM_W-1:0];
            otopic_d = tp_w[TOPIC_W-1:0];
          end else begin
            status_d = ST_FULL;
          end
        end
        REQ_CANCEL, REQ_QUERY: begin
          if (!id_in_range) begin
            status_d = ST_RANGE;
          end else if (!rd_used_q) begin
            status_d = ST_NOTSUB;
            slot_d   = id_slot_w[SLOT_NUM_W-1:0];
          end else begin
            slot_d = id_slot_w[SLOT_NUM_W-1:0];
            if (req_q == REQ_QUERY) begin
              otopic_d = rdt_w[TOPIC_W-1:0];
            end
          end
        end
        REQ_MATCH: begin
          if (cnt_q != '0) begin
            status_d = ST_OVERFLOW;
            total_d  = total_sat;
          end
        end
        REQ_COUNT: begin
          total_d = total_sat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.reply_load || cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply_load || cmd_i.emit_load) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      otopic_q <= otopic_d;
      total_q  <= total_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_number_o    = slot_q;
  assign slot_topic_out_o = otopic_q;
  assign total_o          = total_q;
  assign last_o           = last_q;

endmodule

/* hdl/topic_subscription_table.sv */
// ----------------------------------------------------------------------------
// topic_subscription_table
// Fixed slot table of topic subscriptions with subscribe, cancel, query,
// match and count requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o) carries req_type_i, topic_i and
//   slot_id_i; a transaction completes when valid is high and stall is low.
//   Results leave on out_valid_o / out_stall_i, last_o marking the final one
//   of a request. Configuration writes use cfg_valid_i / cfg_ready_o with
//   cfg_index_i and cfg_data_i; they are taken at any time but are only
//   meaningful while the table is idle.
//   One request is worked on at a time. Cancel and query do one lookup read
//   of the addressed slot and then reply. Subscribe, match and count scan the
//   first n slots one per cycle through the topic memory read port, n being
//   slots_in_use capped at NUM_SLOTS. A match that lists its slots walks the
//   hit vector again, one slot per cycle, a hit slot waiting while the output
//   register is stalled.
//   Reset frees every slot and sets both registers to 32.
//   A stalled result holds in the output register; the next request is
//   accepted meanwhile, and its result waits until that register drains.
// ----------------------------------------------------------------------------
module topic_subscription_table #(
  parameter int unsigned NUM_SLOTS  = tst_pkg::NUM_SLOTS_DEF,
  parameter int unsigned TOPIC_BITS = tst_pkg::TOPIC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tst_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tst_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tst_pkg::REQ_W-1:0]         req_type_i,
  input  logic [tst_pkg::TOPIC_W-1:0]       topic_i,
  input  logic [tst_pkg::SLOT_ID_W-1:0]     slot_id_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tst_pkg::STATUS_W-1:0]      status_o,
  output logic [tst_pkg::SLOT_NUM_W-1:0]    slot_number_o,
  output logic [tst_pkg::TOPIC_W-1:0]       slot_topic_out_o,
  output logic [tst_pkg::TOTAL_W-1:0]       total_o,
  output logic                              last_o
);
  import tst_pkg::*;

  tst_cmd_t cmd;
  tst_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tst_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TOPIC_BITS (TOPIC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .topic_i          (topic_i),
    .slot_id_i        (slot_id_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .slot_number_o    (slot_number_o),
    .slot_topic_out_o (slot_topic_out_o),
    .total_o          (total_o),
    .last_o           (last_o)
  );

  // a known request keeps the input side stalled on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && req_type_i <= REQ_W'(REQ_COUNT)) |=> in_stall_o)
    else $error("request accepted while previous one still in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OVERFLOW) |-> (last_o && total_o != '0))
    else $error("overflow result not final or without total");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_RANGE || status_o == ST_FULL)) |->
      (slot_number_o == '0 && total_o == '0 && slot_topic_out_o == '0 && last_o))
    else $error("error result carries payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (status_o == ST_OK && total_o != '0))
    else $error("non-final result outside a match listing");

endmodule
